>>> rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker files.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define CHTH_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("cuckoo hash table assertion failed");

// Check that a condition never holds outside reset
`define CHTH_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("cuckoo hash table forbidden condition seen");

`endif

>>> rtl/core/chth_pkg.sv
// ---------------------------------------------------------------------------
// chth_pkg
// Item types and codes of the cuckoo hash table.
// ---------------------------------------------------------------------------
package chth_pkg;

    localparam int KEY_W = 64;
    localparam int IO_VAL_W = 32;
    localparam int LIMIT_W = 7;
    localparam int CFG_IDX_W = 3;

    // Action codes; the unused code acts as a plain lookup
    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_LOOKUP = 2'd1;
    localparam logic [1:0] ACT_REMOVE = 2'd2;

    // Result status codes
    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_DUPLICATE = 3'd1;
    localparam logic [2:0] ST_FULL = 3'd2;
    localparam logic [2:0] ST_FOUND = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MULT_FIRST = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ADD_FIRST = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MOD_FIRST = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MULT_SECOND = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ADD_SECOND = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MOD_SECOND = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_KICK_LIMIT = 3'd6;

    typedef struct packed {
        logic [1:0]          action;
        logic [KEY_W-1:0]    key;
        logic [IO_VAL_W-1:0] value_in;
    } in_item_t;

    typedef struct packed {
        logic [2:0]          status;
        logic [IO_VAL_W-1:0] value_out;
        logic [KEY_W-1:0]    homeless_key;
        logic [IO_VAL_W-1:0] homeless_value;
    } out_item_t;

    // Coefficients of one hash function
    typedef struct packed {
        logic [KEY_W-1:0] mult;
        logic [KEY_W-1:0] add;
        logic [KEY_W-1:0] modulus;
    } hash_cfg_t;

endpackage

>>> rtl/core/chth_ram.sv
// ---------------------------------------------------------------------------
// chth_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module chth_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/chth_hash.sv
// ---------------------------------------------------------------------------
// chth_hash
// Sequential hash unit: (mult*key+add) mod modulus; the slot is its low bits.
// Shared 32x32 multiplier over three steps, restoring divider one bit a cycle
// for the run-time modulus.
// ---------------------------------------------------------------------------
module chth_hash #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  chth_pkg::hash_cfg_t            cfg,
    input  logic [chth_pkg::KEY_W-1:0]     key,
    output logic                           done,
    output logic [$clog2(TABLE_DEPTH)-1:0] slot
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int KW = chth_pkg::KEY_W;
    localparam int HW = KW / 2;

    typedef enum logic [3:0] {
        H_IDLE = 4'b0001,
        H_MUL  = 4'b0010,
        H_ADD  = 4'b0100,
        H_DIV  = 4'b1000
    } hstate_t;

    hstate_t state_reg, state_next;
    logic [1:0] step_reg, step_next;
    logic [5:0] cnt_reg, cnt_next;
    logic done_reg, done_next;
    logic [KW-1:0] a_reg, a_next;
    logic [KW-1:0] b_reg, b_next;
    logic [KW-1:0] add_reg, add_next;
    logic [KW-1:0] mod_reg, mod_next;
    logic [KW-1:0] acc_reg, acc_next;
    logic [KW-1:0] dvd_reg, dvd_next;
    logic [KW-1:0] rem_reg, rem_next;
    logic [KW-1:0] dvs_reg, dvs_next;

    logic [HW-1:0] op_a, op_b;
    logic [KW-1:0] prod;
    logic [KW:0]   rem_sh;
    logic [KW:0]   rem_diff;
    logic [KW-1:0] rem_step;
    logic [KW-1:0] hsum;

    // Shared multiplier operands
    always_comb
    begin
        unique case (step_reg)
            2'd0:    begin op_a = a_reg[HW-1:0];  op_b = b_reg[HW-1:0];  end
            2'd1:    begin op_a = a_reg[HW-1:0];  op_b = b_reg[KW-1:HW]; end
            default: begin op_a = a_reg[KW-1:HW]; op_b = b_reg[HW-1:0];  end
        endcase
    end

    assign prod = op_a * op_b;
    assign hsum = acc_reg + add_reg;

    // One restoring division step
    assign rem_sh = {rem_reg, dvd_reg[KW-1]};
    assign rem_diff = rem_sh - {1'b0, dvs_reg};
    assign rem_step = (rem_sh >= {1'b0, dvs_reg}) ? rem_diff[KW-1:0] : rem_sh[KW-1:0];

    always_comb
    begin
        state_next = state_reg;
        step_next = step_reg;
        cnt_next = cnt_reg;
        done_next = 1'b0;
        a_next = a_reg;
        b_next = b_reg;
        add_next = add_reg;
        mod_next = mod_reg;
        acc_next = acc_reg;
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        unique case (state_reg)
            H_IDLE:
            begin
                // Latch operands for a new hash
                if (start)
                begin
                    a_next = key;
                    b_next = cfg.mult;
                    add_next = cfg.add;
                    mod_next = cfg.modulus;
                    step_next = 2'd0;
                    state_next = H_MUL;
                end
            end
            H_MUL:
            begin
                // Accumulate low 64 bits of the product
                if (step_reg == 2'd0)
                begin
                    acc_next = prod;
                end
                else
                begin
                    acc_next = acc_reg + {prod[HW-1:0], {HW{1'b0}}};
                end
                if (step_reg == 2'd2)
                begin
                    state_next = H_ADD;
                end
                else
                begin
                    step_next = step_reg + 2'd1;
                end
            end
            H_ADD:
            begin
                // Zero modulus means no reduction: the sum is the hash
                dvd_next = hsum;
                rem_next = '0;
                cnt_next = '0;
                dvs_next = mod_reg;
                if (mod_reg == '0)
                begin
                    rem_next = hsum;
                    done_next = 1'b1;
                    state_next = H_IDLE;
                end
                else
                begin
                    state_next = H_DIV;
                end
            end
            H_DIV:
            begin
                dvd_next = {dvd_reg[KW-2:0], 1'b0};
                rem_next = rem_step;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    done_next = 1'b1;
                    state_next = H_IDLE;
                end
            end
            default:
            begin
                state_next = H_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= H_IDLE;
            step_reg <= '0;
            cnt_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg <= step_next;
            cnt_reg <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        add_reg <= add_next;
        mod_reg <= mod_next;
        acc_reg <= acc_next;
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    // TABLE_DEPTH is a power of two: the slot is the low bits of the hash
    assign done = done_reg;
    assign slot = rem_reg[ADDR_W-1:0];

endmodule

>>> rtl/core/cuckoo_hash_table.sv
// ---------------------------------------------------------------------------
// cuckoo_hash_table
// Two-table cuckoo hash store of 64-bit keys with value words.
// ---------------------------------------------------------------------------
// Usage:
//   in_data (action, key, value_in) is taken on in_valid with in_stall low.
//   Each item gives one out_data item (status, value_out, homeless entry)
//   on out_valid; the receiver holds it with out_stall.
//   cfg_valid/cfg_ready write hash coefficients and kick_limit by cfg_index;
//   write only while the block is idle. cfg_ready is always high.
// Processing:
//   One hash is 3 multiply steps, one add and a restoring division by the
//   modulus; the slot is the low bits of the result. A zero modulus skips the
//   division. Each table probe is a hash, then a memory read and check.
//   Items are handled one at a time; a lookup makes one or two probes, an
//   insert up to kick_limit.
// Reset:
//   After reset a clearing pass writes every slot of both tables empty, with
//   in_stall high.
// Stall:
//   A finished result waits in the output register; the next item is accepted
//   meanwhile, and its result waits inside, in_stall high, until the output frees.
// ---------------------------------------------------------------------------
module cuckoo_hash_table #(
    parameter int TABLE_DEPTH = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  chth_pkg::in_item_t                in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output chth_pkg::out_item_t               out_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [chth_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [chth_pkg::KEY_W-1:0]        cfg_data
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int KW = chth_pkg::KEY_W;
    localparam int LW = chth_pkg::LIMIT_W;
    localparam int ENT_W = 1 + KW + VALUE_WIDTH;
    localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(TABLE_DEPTH - 1);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_HASH  = 5'b00100,
        S_CHECK = 5'b01000,
        S_WAIT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic [ADDR_W-1:0] slot_reg, slot_next;
    logic [1:0] act_reg, act_next;
    logic [KW-1:0] key_reg, key_next;
    logic [VALUE_WIDTH-1:0] val_reg, val_next;
    logic tab_reg, tab_next;
    logic [LW-1:0] kick_reg, kick_next;
    chth_pkg::out_item_t res_reg, res_next;
    chth_pkg::out_item_t out_reg, out_next;
    logic out_valid_reg, out_valid_next;

    chth_pkg::hash_cfg_t cfg_first_reg, cfg_second_reg;
    logic [LW-1:0] limit_reg;

    logic hash_start;
    logic hash_tab;
    logic [KW-1:0] hash_key;
    chth_pkg::hash_cfg_t hash_cfg;
    logic hash_done;
    logic [ADDR_W-1:0] hash_slot;

    logic [1:0] ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ENT_W-1:0] ram_wdata;
    logic [ENT_W-1:0] rdata0, rdata1, ent;
    logic ent_valid;
    logic [KW-1:0] ent_key;
    logic [VALUE_WIDTH-1:0] ent_val;
    logic [LW-1:0] kick_inc;

    logic finish;
    chth_pkg::out_item_t fin_res;
    logic out_free;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_first_reg <= '{mult: 64'd1, add: 64'd0, modulus: 64'd4294967291};
            cfg_second_reg <= '{mult: 64'd3, add: 64'd7, modulus: 64'd4294967279};
            limit_reg <= 7'd16;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                chth_pkg::REG_MULT_FIRST:  cfg_first_reg.mult <= cfg_data;
                chth_pkg::REG_ADD_FIRST:   cfg_first_reg.add <= cfg_data;
                chth_pkg::REG_MOD_FIRST:   cfg_first_reg.modulus <= cfg_data;
                chth_pkg::REG_MULT_SECOND: cfg_second_reg.mult <= cfg_data;
                chth_pkg::REG_ADD_SECOND:  cfg_second_reg.add <= cfg_data;
                chth_pkg::REG_MOD_SECOND:  cfg_second_reg.modulus <= cfg_data;
                chth_pkg::REG_KICK_LIMIT:  limit_reg <= cfg_data[LW-1:0];
                default:                   ;
            endcase
        end
    end

    // Hash unit and tables
    assign hash_cfg = hash_tab ? cfg_second_reg : cfg_first_reg;

    chth_hash #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_hash (
        .clk(clk),
        .rst_n(rst_n),
        .start(hash_start),
        .cfg(hash_cfg),
        .key(hash_key),
        .done(hash_done),
        .slot(hash_slot)
    );

    chth_ram #(
        .WIDTH(ENT_W),
        .DEPTH(TABLE_DEPTH)
    ) u_ram_first (
        .clk(clk),
        .we(ram_we[0]),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(hash_slot),
        .rdata(rdata0)
    );

    chth_ram #(
        .WIDTH(ENT_W),
        .DEPTH(TABLE_DEPTH)
    ) u_ram_second (
        .clk(clk),
        .we(ram_we[1]),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(hash_slot),
        .rdata(rdata1)
    );

    // Split the entry read at the probed slot
    assign ent = tab_reg ? rdata1 : rdata0;
    assign ent_valid = ent[ENT_W-1];
    assign ent_key = ent[ENT_W-2 -: KW];
    assign ent_val = ent[VALUE_WIDTH-1:0];
    assign kick_inc = kick_reg + 7'd1;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != S_IDLE);

    // Control sequencer
    always_comb
    begin
        state_next = state_reg;
        clr_next = clr_reg;
        slot_next = slot_reg;
        act_next = act_reg;
        key_next = key_reg;
        val_next = val_reg;
        tab_next = tab_reg;
        kick_next = kick_reg;
        res_next = res_reg;
        hash_start = 1'b0;
        hash_tab = 1'b0;
        hash_key = key_reg;
        ram_we = 2'b00;
        ram_waddr = slot_reg;
        ram_wdata = {1'b1, key_reg, val_reg};
        finish = 1'b0;
        fin_res = '{status: chth_pkg::ST_NOT_FOUND, value_out: '0,
                    homeless_key: '0, homeless_value: '0};
        unique case (state_reg)
            S_CLEAR:
            begin
                // Empty every slot of both tables
                ram_we = 2'b11;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == LAST_SLOT)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    act_next = in_data.action;
                    key_next = in_data.key;
                    val_next = VALUE_WIDTH'(in_data.value_in);
                    tab_next = 1'b0;
                    kick_next = '0;
                    if (in_data.action == chth_pkg::ACT_INSERT && limit_reg == '0)
                    begin
                        // No attempt allowed: the new entry is homeless
                        finish = 1'b1;
                        fin_res.status = chth_pkg::ST_FULL;
                        fin_res.homeless_key = in_data.key;
                        fin_res.homeless_value =
                            chth_pkg::IO_VAL_W'(VALUE_WIDTH'(in_data.value_in));
                    end
                    else
                    begin
                        hash_start = 1'b1;
                        hash_key = in_data.key;
                        state_next = S_HASH;
                    end
                end
            end
            S_HASH:
            begin
                // Slot address goes to the memories as the hash finishes
                if (hash_done)
                begin
                    slot_next = hash_slot;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                hash_tab = !tab_reg;
                if (act_reg == chth_pkg::ACT_INSERT)
                begin
                    if (!ent_valid)
                    begin
                        ram_we[tab_reg] = 1'b1;
                        finish = 1'b1;
                        fin_res.status = chth_pkg::ST_INSERTED;
                    end
                    else if (ent_key == key_reg)
                    begin
                        finish = 1'b1;
                        fin_res.status = chth_pkg::ST_DUPLICATE;
                    end
                    else
                    begin
                        // Swap in the carried entry, carry the occupant onward
                        ram_we[tab_reg] = 1'b1;
                        key_next = ent_key;
                        val_next = ent_val;
                        tab_next = !tab_reg;
                        kick_next = kick_inc;
                        if (kick_inc == limit_reg)
                        begin
                            finish = 1'b1;
                            fin_res.status = chth_pkg::ST_FULL;
                            fin_res.homeless_key = ent_key;
                            fin_res.homeless_value = chth_pkg::IO_VAL_W'(ent_val);
                        end
                        else
                        begin
                            hash_start = 1'b1;
                            hash_key = ent_key;
                            state_next = S_HASH;
                        end
                    end
                end
                else if (ent_valid && ent_key == key_reg)
                begin
                    // Hit; drop the valid bit on remove
                    finish = 1'b1;
                    fin_res.status = chth_pkg::ST_FOUND;
                    fin_res.value_out = chth_pkg::IO_VAL_W'(ent_val);
                    if (act_reg == chth_pkg::ACT_REMOVE)
                    begin
                        ram_we[tab_reg] = 1'b1;
                        ram_wdata = {1'b0, ent_key, ent_val};
                    end
                end
                else if (!tab_reg)
                begin
                    tab_next = 1'b1;
                    hash_start = 1'b1;
                    state_next = S_HASH;
                end
                else
                begin
                    finish = 1'b1;
                end
            end
            S_WAIT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (finish)
        begin
            res_next = fin_res;
            state_next = out_free ? S_IDLE : S_WAIT;
        end
    end

    // Output register
    always_comb
    begin
        out_next = out_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (finish && out_free)
        begin
            out_next = fin_res;
            out_valid_next = 1'b1;
        end
        else if (state_reg == S_WAIT && out_free)
        begin
            out_next = res_reg;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
        act_reg <= act_next;
        key_reg <= key_next;
        val_reg <= val_next;
        tab_reg <= tab_next;
        kick_reg <= kick_next;
        res_reg <= res_next;
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

endmodule

>>> rtl/core/chth_checker.sv
// ---------------------------------------------------------------------------
// chth_checker
// Port-level checks of the cuckoo hash table result channel.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module chth_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_stall,
    input chth_pkg::out_item_t out_data
);

    // Hold a stalled item
    `CHTH_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data))

    // Status is one of the five defined codes
    `CHTH_NEVER(a_status_code, out_valid && out_data.status > chth_pkg::ST_NOT_FOUND)

    // Homeless entry is zero unless the table was full
    `CHTH_NEVER(a_homeless_zero, out_valid && out_data.status != chth_pkg::ST_FULL &&
        (out_data.homeless_key != '0 || out_data.homeless_value != '0))

    // Value word is zero unless found
    `CHTH_NEVER(a_value_zero, out_valid && out_data.status != chth_pkg::ST_FOUND &&
        out_data.value_out != '0)

endmodule

bind cuckoo_hash_table chth_checker u_chth_checker (
    .clk(clk),
    .rst_n(rst_n),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
);
